@@ rtl/assert_macros.svh @@
// assertion macros used by the rtl of the lsb pixel extractor
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/lspe_pkg.sv @@
// types and constants of the lsb pixel extractor
`default_nettype none

package lspe_pkg;

   localparam int NUM_LANES    = 3;
   localparam int ITEMS_MAX    = 3;
   localparam int SUFFIX_BYTES = 8;
   localparam int LENGTH_BYTES = 4;
   localparam int HEADER_BYTES = 13;

   localparam logic [7:0] BLANK_BYTE = 8'h20;
   localparam logic [3:0] BITS_MIN   = 4'd1;
   localparam logic [3:0] BITS_MAX   = 4'd8;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_IDLE    = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] bits;
      logic [3:0] width;
   } lane_out_type;

   typedef struct packed {
      logic [7:0]  byte_value;
      logic        is_header_byte;
      logic        end_of_payload;
      logic        last_of_pixel;
      logic [31:0] payload_length;
      logic        header_ok;
   } result_type;

   typedef struct packed {
      logic [1:0]                     count;
      result_type [ITEMS_MAX-1:0]     items;
   } bundle_type;

endpackage

`default_nettype wire

@@ rtl/lspe_lane.sv @@
// one colour channel lane: picks the hidden bits, first bit at the msb
`default_nettype none

module lspe_lane (
   input  logic [7:0]                chan_value,
   input  logic [3:0]                width,
   output lspe_pkg::lane_out_type    lane_out
);

   logic [7:0] reversed;
   logic [7:0] mask;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         reversed[7-i] = chan_value[i];
      end
      mask           = 8'hFF << (4'd8 - width);
      lane_out.bits  = reversed & mask;
      lane_out.width = width;
   end

endmodule

`default_nettype wire

@@ rtl/lspe_merge.sv @@
// merges the lane bits with the held bits, cuts bytes and tracks header and payload
`default_nettype none

module lspe_merge (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            accept,
   input  logic                                            frame_start,
   input  logic [3:0]                                      eff_bits,
   input  lspe_pkg::lane_out_type [lspe_pkg::NUM_LANES-1:0] lane_in,
   output logic [lspe_pkg::NUM_LANES-1:0][3:0]             lane_width,
   output logic                                            push,
   output lspe_pkg::bundle_type                            bundle
);

   localparam int         HEADER_BITS  = lspe_pkg::HEADER_BYTES * 8;
   localparam logic [3:0] LAST_HDR_IDX = 4'(lspe_pkg::HEADER_BYTES - 1);

   lspe_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [6:0]  acc_ff, acc_in, cur_acc;
   logic [2:0]  held_ff, held_in, cur_held;
   logic [3:0]  hdr_cnt_ff, hdr_cnt_in, cur_hdr_cnt;
   logic [31:0] rem_ff, rem_in, cur_rem;
   logic [31:0] len_ff, len_in, cur_len;
   logic        sfx_ff, sfx_in, cur_sfx;
   logic        ok_ff, ok_in, cur_ok;

   logic [6:0]  hdr_bits;
   logic [4:0]  pos [lspe_pkg::NUM_LANES+1];
   logic [4:0]  total;
   logic [31:0] word;
   logic [31:0] shifted;
   logic [7:0]  leftover;
   logic        active;
   logic [1:0]  nb;
   logic [7:0]  byte0;
   logic        hdr_byte;
   logic        hdr_done;
   logic        pay_mode;
   logic [31:0] rem_base;
   logic        ok_new;
   logic        ok_val;
   logic [1:0]  count;
   logic [1:0]  pay_cnt;
   logic        stop;
   logic        ended;
   logic        is_hdr_k;
   logic        is_pay_k;
   logic        end_k;

   // frame start clears the state ahead of this pixel
   always_comb begin
      if (frame_start) begin
         cur_phase   = lspe_pkg::PH_HEADER;
         cur_acc     = '0;
         cur_held    = '0;
         cur_hdr_cnt = '0;
         cur_rem     = '0;
         cur_len     = '0;
         cur_sfx     = 1'b0;
         cur_ok      = 1'b0;
      end else begin
         cur_phase   = phase_ff;
         cur_acc     = acc_ff;
         cur_held    = held_ff;
         cur_hdr_cnt = hdr_cnt_ff;
         cur_rem     = rem_ff;
         cur_len     = len_ff;
         cur_sfx     = sfx_ff;
         cur_ok      = ok_ff;
      end
   end

   // a lane takes one bit while the header is still open at its start
   always_comb begin
      hdr_bits = {cur_hdr_cnt, cur_held};
      for (int c = 0; c < lspe_pkg::NUM_LANES; c++) begin
         lane_width[c] = (cur_phase == lspe_pkg::PH_HEADER &&
                          hdr_bits < 7'(HEADER_BITS - c)) ? 4'd1 : eff_bits;
      end
   end

   always_comb begin
      pos[0] = {2'b00, cur_held};
      for (int c = 0; c < lspe_pkg::NUM_LANES; c++) begin
         pos[c+1] = pos[c] + {1'b0, lane_in[c].width};
      end
      total = pos[lspe_pkg::NUM_LANES];

      word = {cur_acc, 25'd0} << (3'd7 - cur_held);
      for (int c = 0; c < lspe_pkg::NUM_LANES; c++) begin
         word = word | ({lane_in[c].bits, 24'd0} >> pos[c]);
      end

      active   = cur_phase != lspe_pkg::PH_IDLE;
      nb       = active ? total[4:3] : 2'd0;
      byte0    = word[31:24];
      hdr_byte = (cur_phase == lspe_pkg::PH_HEADER) && (nb != 2'd0);
      hdr_done = hdr_byte && (cur_hdr_cnt == LAST_HDR_IDX);
      pay_mode = (cur_phase == lspe_pkg::PH_PAYLOAD) || (hdr_done && cur_len != 32'd0);
      rem_base = hdr_done ? cur_len : cur_rem;
      ok_new   = cur_sfx && (cur_len != 32'd0) &&
                 (byte0 >= {4'd0, lspe_pkg::BITS_MIN}) && (byte0 <= {4'd0, lspe_pkg::BITS_MAX});
      ok_val   = hdr_done ? ok_new : cur_ok;

      count   = 2'd0;
      pay_cnt = 2'd0;
      stop    = 1'b0;
      ended   = 1'b0;
      bundle  = '0;
      for (int k = 0; k < lspe_pkg::ITEMS_MAX; k++) begin
         is_hdr_k = (k == 0) && hdr_byte;
         is_pay_k = !is_hdr_k && pay_mode && (2'(k) < nb);
         end_k    = (is_hdr_k && hdr_done && cur_len == 32'd0) ||
                    (is_pay_k && rem_base == {30'd0, pay_cnt + 2'd1});
         bundle.items[k].byte_value     = word[31-8*k -: 8];
         bundle.items[k].is_header_byte = is_hdr_k;
         bundle.items[k].end_of_payload = end_k;
         bundle.items[k].payload_length = (is_hdr_k && !hdr_done) ? 32'd0 : cur_len;
         bundle.items[k].header_ok      = (is_hdr_k && !hdr_done) ? 1'b0 : ok_val;
         if (!stop && (2'(k) < nb) && (is_hdr_k || is_pay_k)) begin
            count = count + 2'd1;
            if (is_pay_k) begin
               pay_cnt = pay_cnt + 2'd1;
            end
            if (end_k) begin
               stop  = 1'b1;
               ended = 1'b1;
            end
         end
      end
      for (int k = 0; k < lspe_pkg::ITEMS_MAX; k++) begin
         bundle.items[k].last_of_pixel = (2'(k) == count - 2'd1);
      end
      bundle.count = count;
      push         = accept && (count != 2'd0);

      // bits left over after the last whole byte
      shifted  = word << {nb, 3'b000};
      leftover = shifted[31:24] >> (4'd8 - {1'b0, total[2:0]});
      acc_in   = (ended || !active) ? 7'd0 : leftover[6:0];
      held_in  = (ended || !active) ? 3'd0 : total[2:0];

      hdr_cnt_in = hdr_byte ? cur_hdr_cnt + 4'd1 : cur_hdr_cnt;
      sfx_in     = cur_sfx | (hdr_byte && cur_hdr_cnt < 4'(lspe_pkg::SUFFIX_BYTES) &&
                              byte0 != lspe_pkg::BLANK_BYTE);
      len_in     = cur_len;
      for (int j = 0; j < lspe_pkg::LENGTH_BYTES; j++) begin
         if (hdr_byte && cur_hdr_cnt == 4'(lspe_pkg::SUFFIX_BYTES + j) &&
             byte0 != lspe_pkg::BLANK_BYTE) begin
            len_in[8*j +: 8] = cur_len[8*j +: 8] | byte0;
         end
      end
      ok_in  = ok_val;
      rem_in = rem_base - {30'd0, pay_cnt};
   end

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (ended) begin
            phase_in = lspe_pkg::PH_IDLE;
         end else if (hdr_done) begin
            phase_in = lspe_pkg::PH_PAYLOAD;
         end else begin
            phase_in = cur_phase;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= lspe_pkg::PH_HEADER;
         acc_ff     <= '0;
         held_ff    <= '0;
         hdr_cnt_ff <= '0;
         rem_ff     <= '0;
         len_ff     <= '0;
         sfx_ff     <= 1'b0;
         ok_ff      <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (accept) begin
            acc_ff     <= acc_in;
            held_ff    <= held_in;
            hdr_cnt_ff <= hdr_cnt_in;
            rem_ff     <= rem_in;
            len_ff     <= len_in;
            sfx_ff     <= sfx_in;
            ok_ff      <= ok_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/lspe_result_fifo.sv @@
// two-deep queue of per-pixel result bundles, drained one byte per transaction
`default_nettype none

module lspe_result_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lspe_pkg::bundle_type    push_bundle,
   output logic                    push_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lspe_pkg::result_type    rsp_item
);

   lspe_pkg::bundle_type slot_ff [2];
   lspe_pkg::bundle_type head;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic [1:0] item_ff, item_in;
   logic       pop_item;
   logic       pop_bundle;

   always_comb begin
      head       = slot_ff[rd_ptr_ff];
      push_ready = fill_ff != 2'd2;
      rsp_valid  = fill_ff != 2'd0;
      rsp_item   = head.items[item_ff];
      pop_item   = rsp_valid && rsp_ready;
      pop_bundle = pop_item && (item_ff == head.count - 2'd1);
      fill_in    = fill_ff + {1'b0, push} - {1'b0, pop_bundle};
      wr_ptr_in  = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop_bundle ? ~rd_ptr_ff : rd_ptr_ff;
      item_in    = pop_bundle ? 2'd0 : (pop_item ? item_ff + 2'd1 : item_ff);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
         item_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         item_ff   <= item_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lsb_stego_pixel_extractor_unit.sv @@
// top level of the lsb pixel extractor: csr, channel lanes, merge stage and result queue
//
// req_ takes one rgb pixel per transaction in raster order; req_frame_start marks the
// first pixel of an image and clears the extraction state before that pixel.
// csr_ writes bit_count, the payload bits per channel; it is always ready. The user must
// see that it is written only while the block is idle; the block does not enforce this.
// Values 0 and 9..15 act as 1 and 8. rsp_ returns the recovered bytes, zero to three
// per pixel, one per transaction, with last_of_pixel on the final byte of each pixel.
// The three channel lanes and the merge stage handle a whole pixel in the cycle it is
// accepted and push its bytes into a queue of two pixel bundles in front of rsp_, so a
// pixel is accepted every cycle while the queue has room. The rsp_ port moves one byte
// per cycle while rsp_ready is high; in the payload a pixel carries 3*bit_count/8 bytes
// on average.
// Reset sets bit_count to 1, empties the queue and opens the header phase.
// When rsp_ready stays low the queue fills after two pixels that carry bytes and
// req_ready drops; pixels that carry no byte never enter the queue.
// After the last payload byte the block returns nothing until the next frame start.
`default_nettype none

module lsb_stego_pixel_extractor_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_frame_start,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_byte_value,
   output logic        rsp_is_header_byte,
   output logic        rsp_end_of_payload,
   output logic        rsp_last_of_pixel,
   output logic [31:0] rsp_payload_length,
   output logic        rsp_header_ok,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_bit_count
);

   logic [3:0] bit_count_ff, bit_count_in;
   logic [3:0] eff_bits;
   logic       accept;
   logic       push;

   logic [lspe_pkg::NUM_LANES-1:0][7:0]       chan_values;
   logic [lspe_pkg::NUM_LANES-1:0][3:0]       lane_width;
   lspe_pkg::lane_out_type [lspe_pkg::NUM_LANES-1:0] lane_out;
   lspe_pkg::bundle_type                      bundle;
   lspe_pkg::result_type                      rsp_item;

   assign csr_ready = 1'b1;

   always_comb begin
      bit_count_in = (csr_valid && csr_ready) ? csr_bit_count : bit_count_ff;
      if (bit_count_ff < lspe_pkg::BITS_MIN) begin
         eff_bits = lspe_pkg::BITS_MIN;
      end else if (bit_count_ff > lspe_pkg::BITS_MAX) begin
         eff_bits = lspe_pkg::BITS_MAX;
      end else begin
         eff_bits = bit_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= lspe_pkg::BITS_MIN;
      end else begin
         bit_count_ff <= bit_count_in;
      end
   end

   assign accept      = req_valid && req_ready;
   assign chan_values = {req_blue, req_green, req_red};

   for (genvar c = 0; c < lspe_pkg::NUM_LANES; c++) begin : g_lane
      lspe_lane u_lane (
         .chan_value (chan_values[c]),
         .width      (lane_width[c]),
         .lane_out   (lane_out[c])
      );
   end

   lspe_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_frame_start),
      .eff_bits    (eff_bits),
      .lane_in     (lane_out),
      .lane_width  (lane_width),
      .push        (push),
      .bundle      (bundle)
   );

   lspe_result_fifo u_result_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (bundle),
      .push_ready  (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item)
   );

   assign rsp_byte_value     = rsp_item.byte_value;
   assign rsp_is_header_byte = rsp_item.is_header_byte;
   assign rsp_end_of_payload = rsp_item.end_of_payload;
   assign rsp_last_of_pixel  = rsp_item.last_of_pixel;
   assign rsp_payload_length = rsp_item.payload_length;
   assign rsp_header_ok      = rsp_item.header_ok;

`include "assert_macros.svh"

   // the final byte always closes its pixel
   `ASSERT_IMPLIES(a_end_closes_pixel, clock, reset, rsp_valid && rsp_end_of_payload, rsp_last_of_pixel)
   // payload bytes exist only with a nonzero length
   `ASSERT_IMPLIES(a_payload_has_length, clock, reset, rsp_valid && !rsp_is_header_byte, rsp_payload_length != 32'd0)
   // a good header needs a nonzero length
   `ASSERT_IMPLIES(a_ok_has_length, clock, reset, rsp_valid && rsp_header_ok, rsp_payload_length != 32'd0)
   // a full queue always has a byte to offer
   `ASSERT_IMPLIES(a_full_has_output, clock, reset, !req_ready, rsp_valid)
   // a full queue stays full while no byte is taken
   `ASSERT_NEXT(a_full_holds, clock, reset, !req_ready && !(rsp_valid && rsp_ready), !req_ready)

endmodule

`default_nettype wire
